/* sv/owm_pkg.sv */
// Shared types and constants for the 1-Wire bus master core.
// Depends on nothing; used by every module in this folder.
package owm_pkg;

	localparam int unsigned TICK_W = 10;
	localparam int unsigned CFG_INDEX_W = 3;

	// Command codes carried in the cmd field.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_LOW     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOT          = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_RECOVERY      = 3'd5;

	// Register reset values.
	localparam logic [TICK_W-1:0] RESET_LOW_DEF     = 10'd480;
	localparam logic [TICK_W-1:0] PRESENCE_WAIT_DEF = 10'd80;
	localparam logic [TICK_W-1:0] RESET_TAIL_DEF    = 10'd400;
	localparam logic [TICK_W-1:0] SHORT_LOW_DEF     = 10'd1;
	localparam logic [TICK_W-1:0] SLOT_DEF          = 10'd50;
	localparam logic [TICK_W-1:0] RECOVERY_DEF      = 10'd1;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_RST_TAIL = 3'd3,
		PH_WR_LOW   = 3'd4,
		PH_WR_REL   = 3'd5,
		PH_RD_LOW   = 3'd6,
		PH_RD_REL   = 3'd7
	} phase_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic       line_level;
	} in_item_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_byte;
		logic       rejected;
	} out_item_t;

	typedef struct packed {
		logic [TICK_W-1:0] reset_low_ticks;
		logic [TICK_W-1:0] presence_wait_ticks;
		logic [TICK_W-1:0] reset_tail_ticks;
		logic [TICK_W-1:0] short_low_ticks;
		logic [TICK_W-1:0] slot_ticks;
		logic [TICK_W-1:0] recovery_ticks;
	} cfg_t;

endpackage

/* sv/owm_cfg_regs.sv */
// Timing register file of the 1-Wire bus master.
// Depends on owm_pkg for the register indexes, reset values and cfg_t.
module owm_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [owm_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [owm_pkg::TICK_W-1:0]         wr_data,
	output owm_pkg::cfg_t                      cfg
);

	owm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks     <= owm_pkg::RESET_LOW_DEF;
			cfg_q.presence_wait_ticks <= owm_pkg::PRESENCE_WAIT_DEF;
			cfg_q.reset_tail_ticks    <= owm_pkg::RESET_TAIL_DEF;
			cfg_q.short_low_ticks     <= owm_pkg::SHORT_LOW_DEF;
			cfg_q.slot_ticks          <= owm_pkg::SLOT_DEF;
			cfg_q.recovery_ticks      <= owm_pkg::RECOVERY_DEF;
		end else if (wr_en) begin
			case (wr_index)
				owm_pkg::REG_RESET_LOW:     cfg_q.reset_low_ticks     <= wr_data;
				owm_pkg::REG_PRESENCE_WAIT: cfg_q.presence_wait_ticks <= wr_data;
				owm_pkg::REG_RESET_TAIL:    cfg_q.reset_tail_ticks    <= wr_data;
				owm_pkg::REG_SHORT_LOW:     cfg_q.short_low_ticks     <= wr_data;
				owm_pkg::REG_SLOT:          cfg_q.slot_ticks          <= wr_data;
				owm_pkg::REG_RECOVERY:      cfg_q.recovery_ticks      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/owm_engine.sv */
// Bus sequencer: phase machine, tick counter, bit shifter and status flags.
// Depends on owm_pkg; one tick of bus time per asserted step.
module owm_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  owm_pkg::in_item_t   item,
	input  owm_pkg::cfg_t       cfg,
	output owm_pkg::out_item_t  res
);

	localparam int unsigned TW = owm_pkg::TICK_W;

	owm_pkg::phase_t phase_q, phase_d, ph0;
	logic [TW-1:0]   tick_q, tick_d, tc0, tc_inc, len;
	logic [2:0]      bit_q, bit_d, bi0;
	logic [7:0]      shift_q, shift_d, sb0, sb1;
	logic            pres_q, pres_d;
	logic [7:0]      last_q, last_d;
	logic            start, cmd_hit, cur_bit, expire, last_bit;

	// Resolve a starting command into the phase this tick runs in.
	always_comb begin
		cmd_hit = (item.cmd != owm_pkg::CMD_TICK);
		start   = cmd_hit && (phase_q == owm_pkg::PH_IDLE);
		ph0     = phase_q;
		tc0     = tick_q;
		bi0     = bit_q;
		sb0     = shift_q;
		if (start) begin
			tc0 = '0;
			bi0 = '0;
			case (item.cmd)
				owm_pkg::CMD_RESET: ph0 = owm_pkg::PH_RST_LOW;
				owm_pkg::CMD_WRITE: begin
					ph0 = owm_pkg::PH_WR_LOW;
					sb0 = item.data_byte;
				end
				owm_pkg::CMD_READ: begin
					ph0 = owm_pkg::PH_RD_LOW;
					sb0 = '0;
				end
				default: ph0 = phase_q;
			endcase
		end
	end

	// Phase length, sampling and terminal-count compare.
	always_comb begin
		cur_bit = sb0[bi0];
		case (ph0)
			owm_pkg::PH_RST_LOW:  len = cfg.reset_low_ticks;
			owm_pkg::PH_RST_WAIT: len = cfg.presence_wait_ticks;
			owm_pkg::PH_RST_TAIL: len = cfg.reset_tail_ticks;
			owm_pkg::PH_WR_LOW:   len = cur_bit ? cfg.short_low_ticks : cfg.slot_ticks;
			owm_pkg::PH_WR_REL:   len = cur_bit ? cfg.slot_ticks : cfg.recovery_ticks;
			owm_pkg::PH_RD_LOW:   len = cfg.short_low_ticks;
			owm_pkg::PH_RD_REL:   len = cfg.slot_ticks;
			default:              len = TW'(1);
		endcase
		sb1 = sb0;
		if (ph0 == owm_pkg::PH_RD_REL && tc0 == '0 && item.line_level) begin
			sb1[bi0] = 1'b1;
		end
		tc_inc   = tc0 + TW'(1);
		expire   = (ph0 != owm_pkg::PH_IDLE) && (tc_inc >= len);
		last_bit = (bi0 == 3'd7);
	end

	// Next state.
	always_comb begin
		phase_d = ph0;
		tick_d  = tc0;
		bit_d   = bi0;
		shift_d = sb1;
		pres_d  = pres_q;
		last_d  = last_q;
		if (ph0 != owm_pkg::PH_IDLE) begin
			tick_d = expire ? '0 : tc_inc;
		end
		if (expire) begin
			case (ph0)
				owm_pkg::PH_RST_LOW:  phase_d = owm_pkg::PH_RST_WAIT;
				owm_pkg::PH_RST_WAIT: begin
					phase_d = owm_pkg::PH_RST_TAIL;
					pres_d  = !item.line_level;
				end
				owm_pkg::PH_RST_TAIL: phase_d = owm_pkg::PH_IDLE;
				owm_pkg::PH_WR_LOW:   phase_d = owm_pkg::PH_WR_REL;
				owm_pkg::PH_WR_REL: begin
					phase_d = last_bit ? owm_pkg::PH_IDLE : owm_pkg::PH_WR_LOW;
					bit_d   = bi0 + 3'd1;
				end
				owm_pkg::PH_RD_LOW:   phase_d = owm_pkg::PH_RD_REL;
				owm_pkg::PH_RD_REL: begin
					phase_d = last_bit ? owm_pkg::PH_IDLE : owm_pkg::PH_RD_LOW;
					bit_d   = bi0 + 3'd1;
					if (last_bit) begin
						last_d = sb1;
					end
				end
				default: phase_d = owm_pkg::PH_IDLE;
			endcase
		end
	end

	// Result fields for this tick.
	always_comb begin
		res.drive_low = (ph0 == owm_pkg::PH_RST_LOW) || (ph0 == owm_pkg::PH_WR_LOW) ||
		                (ph0 == owm_pkg::PH_RD_LOW);
		res.busy_res  = (phase_d != owm_pkg::PH_IDLE);
		res.done_res  = expire && ((ph0 == owm_pkg::PH_RST_TAIL) ||
		                (last_bit && ((ph0 == owm_pkg::PH_WR_REL) ||
		                              (ph0 == owm_pkg::PH_RD_REL))));
		res.presence  = pres_d;
		res.read_byte = last_d;
		res.rejected  = cmd_hit && !start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owm_pkg::PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			last_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
			last_q  <= last_d;
		end
	end

endmodule

/* sv/one_wire_bus_master_core.sv */
// Top level of the 1-Wire bus master: input stage, sequencer, result stage.
// Depends on owm_pkg, owm_cfg_regs and owm_engine.
//
// Channel   Signals                              Moves
// --------  -----------------------------------  ------------------------------
// in        in_valid, in_ready, in_item          one tick item (cmd, byte, line)
// out       out_valid, out_ready, out_item       one result per tick item
// cfg       cfg_valid, cfg_ready, cfg_index,     one timing register write
//           cfg_data
//
// Each in transfer yields one out transfer via the input and result registers;
// one item per cycle while out_ready stays high.
// Reset clears both stage valid flags, idles the sequencer, loads timing defaults.
// When out stalls, the result register holds and the input register fills;
// in_ready drops only while both are full and out_ready is low.
// Configuration writes are always taken; write only while no item is held.
module one_wire_bus_master_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  owm_pkg::in_item_t                in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output owm_pkg::out_item_t               out_item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [owm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [owm_pkg::TICK_W-1:0]       cfg_data
);

	owm_pkg::cfg_t      cfg;
	owm_pkg::in_item_t  item_s1;
	owm_pkg::out_item_t res, item_s2;
	logic               valid_s1, valid_s2;
	logic               advance, take;

	// Register file accepts a write in every cycle.
	assign cfg_ready = 1'b1;

	owm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Advance the held item into the result register when that slot is free
	// or being emptied this cycle; the engine updates its state on the same edge.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	owm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers: load on transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			item_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

/* dv/one_wire_bus_master_core_tb.sv */
// Self-checking testbench for one_wire_bus_master_core: random and directed tick items,
// scoreboard with its own model of the bus sequencer and timing registers.
// Depends on owm_pkg and the RTL under sv/.
module one_wire_bus_master_core_tb;
	import owm_pkg::*;

	// Longest receiver park, and quiet cycles before the run is declared hung.
	localparam int SINK_PARK_CYCLES = 64;
	localparam int STALL_LIMIT      = 2000;
	// Pipeline depth is two results at most; give the tail a few extra cycles.
	localparam int SETTLE_CYCLES    = 8;

	// Scoreboard: tracks the sequencer state of the bus master as seen through
	// accepted tick items, and holds the results those items must produce.
	class tick_scoreboard;
		cfg_t              timing;
		phase_t            phase;
		logic [TICK_W-1:0] tick_cnt;
		logic [2:0]        bit_idx;
		logic [7:0]        shift_reg;
		logic              presence_seen;
		logic [7:0]        last_byte;
		out_item_t         expected_q[$];
		int unsigned       error_count;

		function new();
			timing = '{
				reset_low_ticks:     RESET_LOW_DEF,
				presence_wait_ticks: PRESENCE_WAIT_DEF,
				reset_tail_ticks:    RESET_TAIL_DEF,
				short_low_ticks:     SHORT_LOW_DEF,
				slot_ticks:          SLOT_DEF,
				recovery_ticks:      RECOVERY_DEF
			};
			phase         = PH_IDLE;
			tick_cnt      = '0;
			bit_idx       = '0;
			shift_reg     = '0;
			presence_seen = 1'b0;
			last_byte     = '0;
			error_count   = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [TICK_W-1:0] val);
			case (idx)
				REG_RESET_LOW:     timing.reset_low_ticks     = val;
				REG_PRESENCE_WAIT: timing.presence_wait_ticks = val;
				REG_RESET_TAIL:    timing.reset_tail_ticks    = val;
				REG_SHORT_LOW:     timing.short_low_ticks     = val;
				REG_SLOT:          timing.slot_ticks          = val;
				REG_RECOVERY:      timing.recovery_ticks      = val;
				default: ;
			endcase
		endfunction

		function bit bus_idle();
			return phase == PH_IDLE;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Length of the current phase; a write slot depends on the bit being sent.
		function logic [TICK_W-1:0] phase_length();
			case (phase)
				PH_RST_LOW:  return timing.reset_low_ticks;
				PH_RST_WAIT: return timing.presence_wait_ticks;
				PH_RST_TAIL: return timing.reset_tail_ticks;
				PH_WR_LOW:   return shift_reg[bit_idx] ? timing.short_low_ticks : timing.slot_ticks;
				PH_WR_REL:   return shift_reg[bit_idx] ? timing.slot_ticks : timing.recovery_ticks;
				PH_RD_LOW:   return timing.short_low_ticks;
				PH_RD_REL:   return timing.slot_ticks;
				default:     return TICK_W'(1);
			endcase
		endfunction

		// Step past one bit slot; return 1 once the eighth bit is done.
		function bit finish_bit(phase_t low_phase);
			if (bit_idx == 3'd7) begin
				phase   = PH_IDLE;
				bit_idx = '0;
				return 1'b1;
			end
			bit_idx++;
			phase = low_phase;
			return 1'b0;
		endfunction

		// Advance the sequencer by one tick and queue the result it must give.
		function void note_tick(in_item_t it);
			out_item_t         r;
			logic [TICK_W-1:0] len;
			r = '0;
			if (it.cmd != CMD_TICK) begin
				if (phase != PH_IDLE) begin
					r.rejected = 1'b1;
				end else begin
					tick_cnt = '0;
					bit_idx  = '0;
					case (it.cmd)
						CMD_RESET: phase = PH_RST_LOW;
						CMD_WRITE: begin
							phase     = PH_WR_LOW;
							shift_reg = it.data_byte;
						end
						default: begin
							phase     = PH_RD_LOW;
							shift_reg = '0;
						end
					endcase
				end
			end
			if (phase != PH_IDLE) begin
				len = phase_length();
				r.drive_low = (phase == PH_RST_LOW) || (phase == PH_WR_LOW) || (phase == PH_RD_LOW);
				// Read slots sample the line on the first released tick only.
				if (phase == PH_RD_REL && tick_cnt == 0 && it.line_level)
					shift_reg[bit_idx] = 1'b1;
				tick_cnt = tick_cnt + 1'b1;
				// A zero length falls through here after one tick, same as a length of one.
				if (tick_cnt >= len) begin
					tick_cnt = '0;
					case (phase)
						PH_RST_LOW:  phase = PH_RST_WAIT;
						PH_RST_WAIT: begin
							presence_seen = !it.line_level;
							phase         = PH_RST_TAIL;
						end
						PH_RST_TAIL: begin
							phase      = PH_IDLE;
							r.done_res = 1'b1;
						end
						PH_WR_LOW:   phase = PH_WR_REL;
						PH_WR_REL:   r.done_res = finish_bit(PH_WR_LOW);
						PH_RD_LOW:   phase = PH_RD_REL;
						PH_RD_REL: begin
							if (finish_bit(PH_RD_LOW)) begin
								r.done_res = 1'b1;
								last_byte  = shift_reg;
							end
						end
						default:     phase = PH_IDLE;
					endcase
				end
			end
			r.busy_res  = (phase != PH_IDLE);
			r.presence  = presence_seen;
			r.read_byte = last_byte;
			expected_q.push_back(r);
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				error_count++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				$error("result %h arrived with no tick outstanding", got);
				error_count++;
				return;
			end
			want = expected_q.pop_front();
			check_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
			check_field("busy_res",  8'(want.busy_res),  8'(got.busy_res));
			check_field("done_res",  8'(want.done_res),  8'(got.done_res));
			check_field("presence",  8'(want.presence),  8'(got.presence));
			check_field("read_byte", want.read_byte,     got.read_byte);
			check_field("rejected",  8'(want.rejected),  8'(got.rejected));
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	in_item_t               in_item   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_item;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]      cfg_data  = '0;

	tick_scoreboard sb = new();

	// Receiver controls, set from the stimulus process; the receiver counts
	// the parks it has served on its own side.
	bit sink_gaps = 1'b0;
	int park_requests = 0;
	int quiet_cycles = 0;

	one_wire_bus_master_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every result transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_item);
	end

	// Watchdog: end the run if no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver: random stall bursts while enabled, one long park on request
	// so the input side backs up, and a steady ready otherwise.
	initial begin : sink_side
		int parks_served;
		parks_served = 0;
		forever begin
			@(posedge clk);
			if (park_requests > parks_served) begin
				parks_served++;
				out_ready <= 1'b0;
				repeat (SINK_PARK_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (sink_gaps && $urandom_range(0, 11) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic in_item_t tick_item(logic [1:0] op, logic [7:0] data, logic line);
		in_item_t it;
		it.cmd        = op;
		it.data_byte  = data;
		it.line_level = line;
		return it;
	endfunction

	// Mostly well-formed traffic: start a command when the bus is free, tick
	// while it runs, and now and then throw a stray command at a busy bus.
	function automatic in_item_t pick_tick();
		in_item_t it;
		it.data_byte  = 8'($urandom);
		it.line_level = 1'($urandom_range(0, 1));
		if (sb.bus_idle())
			it.cmd = $urandom_range(0, 1) ? 2'($urandom_range(CMD_RESET, CMD_READ)) : CMD_TICK;
		else
			it.cmd = ($urandom_range(0, 11) == 0) ?
				2'($urandom_range(CMD_RESET, CMD_READ)) : CMD_TICK;
		return it;
	endfunction

	function automatic cfg_t random_timing(int unsigned lo, int unsigned hi);
		cfg_t t;
		t.reset_low_ticks     = TICK_W'($urandom_range(lo, hi));
		t.presence_wait_ticks = TICK_W'($urandom_range(lo, hi));
		t.reset_tail_ticks    = TICK_W'($urandom_range(lo, hi));
		t.short_low_ticks     = TICK_W'($urandom_range(lo, hi));
		t.slot_ticks          = TICK_W'($urandom_range(lo, hi));
		t.recovery_ticks      = TICK_W'($urandom_range(lo, hi));
		return t;
	endfunction

	// Offer one tick item and hold it until the transfer happens.
	task automatic send_tick(input in_item_t it);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_tick(it);
	endtask

	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop valid and hold off until every expected result has been seen.
	task automatic await_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Empty the pipeline so the timing registers can be rewritten safely.
	task automatic drain_block();
		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all six timing registers back to back; valid stays up in between.
	task automatic load_timing(input cfg_t t);
		logic [CFG_INDEX_W-1:0] idx [6];
		logic [TICK_W-1:0]      val [6];
		idx = '{REG_RESET_LOW, REG_PRESENCE_WAIT, REG_RESET_TAIL,
			REG_SHORT_LOW, REG_SLOT, REG_RECOVERY};
		val = '{t.reset_low_ticks, t.presence_wait_ticks, t.reset_tail_ticks,
			t.short_low_ticks, t.slot_ticks, t.recovery_ticks};
		cfg_valid <= 1'b1;
		for (int i = 0; i < 6; i++) begin
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Start one command, then tick with a fixed line level until the bus is
	// free again; the second follow-up tick carries a stray command.
	task automatic directed_op(input logic [1:0] op, input logic [7:0] data, input logic line,
			input logic [1:0] stray_cmd);
		int n;
		send_tick(tick_item(op, data, line));
		n = 0;
		while (!sb.bus_idle()) begin
			send_tick(tick_item((n == 1) ? stray_cmd : CMD_TICK, data, line));
			n++;
		end
	endtask

	task automatic run_random(input int count, input bit gaps, input int park_at,
			input int drain_at);
		for (int k = 0; k < count; k++) begin
			if (k == park_at)
				park_requests++;
			if (k == drain_at)
				await_results();
			send_tick(pick_tick());
			if (gaps && $urandom_range(0, 7) == 0)
				pause_sender($urandom_range(1, 12));
		end
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: short timings so each operation stays brief. Zero lengths
		// on presence wait and slot must behave like one tick.
		load_timing('{reset_low_ticks: 10'd1, presence_wait_ticks: 10'd0,
			reset_tail_ticks: 10'd2, short_low_ticks: 10'd1, slot_ticks: 10'd0,
			recovery_ticks: 10'd1});
		send_tick(tick_item(CMD_TICK, 8'hFF, 1'b0));
		send_tick(tick_item(CMD_TICK, 8'h00, 1'b1));
		// Reset with the line pulled low by a device, then with nobody there.
		directed_op(CMD_RESET, 8'h00, 1'b0, CMD_TICK);
		directed_op(CMD_RESET, 8'hFF, 1'b1, CMD_WRITE);
		// Mixed bits exercise both write slot shapes; read a floating-high bus.
		directed_op(CMD_WRITE, 8'hA5, 1'b1, CMD_READ);
		directed_op(CMD_READ, 8'h00, 1'b1, CMD_RESET);
		drain_block();

		// Random phases across several timing settings.
		sink_gaps = 1'b1;
		load_timing(random_timing(1, 3));
		run_random(250, 1'b1, -1, 120);
		drain_block();
		load_timing(random_timing(1, 8));
		run_random(250, 1'b1, 100, -1);
		drain_block();
		load_timing('{reset_low_ticks: RESET_LOW_DEF, presence_wait_ticks: PRESENCE_WAIT_DEF,
			reset_tail_ticks: RESET_TAIL_DEF, short_low_ticks: SHORT_LOW_DEF,
			slot_ticks: SLOT_DEF, recovery_ticks: RECOVERY_DEF});
		run_random(350, 1'b1, -1, -1);
		drain_block();
		load_timing('{default: 10'h3FF});
		run_random(150, 1'b1, -1, -1);
		drain_block();

		// Last stretch at minimum timings, full throughput on both sides.
		sink_gaps = 1'b0;
		load_timing('{default: 10'd1});
		run_random(150, 1'b0, -1, -1);

		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
